// File: src/pfba_pkg.sv
// Shared types and constants for the page frame bitmap allocator.
// No dependencies; other files refer to it by scoped names or import it.
`default_nettype none

package pfba_pkg;

    localparam int NUM_WORDS_DEF  = 512;
    localparam int NUM_FRAMES_DEF = 16384;

    localparam int FRAME_W  = 14;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 15;
    localparam int CMD_W    = 2;
    localparam int WORD_W   = 32;
    localparam int BIT_W    = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_FREE    = 2'd1,
        CMD_RESERVE = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK           = 2'd0,
        STAT_EXHAUSTED    = 2'd1,
        STAT_DOUBLE_FREE  = 2'd2,
        STAT_RESERVE_USED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR = 2'd0,
        S_IDLE  = 2'd1,
        S_EVAL  = 2'd2
    } t_state;

    // Per-word findings handed from the word evaluator to the sequencer.
    typedef struct packed {
        logic              has_clear;
        logic [BIT_W-1:0]  low_bit;
        logic              bit_used;
        logic [WORD_W-1:0] word_low_set;
        logic [WORD_W-1:0] word_bit_set;
        logic [WORD_W-1:0] word_bit_clr;
    } t_word_eval;

endpackage

`default_nettype wire

// File: src/pfba_bitmap_ram.sv
// Single-port-write, single-port-read bitmap memory with registered read data.
// Depends on pfba_pkg for the word width.
`default_nettype none

module pfba_bitmap_ram #(
    parameter int DEPTH = pfba_pkg::NUM_WORDS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_we,
    input  wire logic [AW-1:0]               i_waddr,
    input  wire logic [pfba_pkg::WORD_W-1:0] i_wdata,
    input  wire logic                        i_re,
    input  wire logic [AW-1:0]               i_raddr,
    output logic      [pfba_pkg::WORD_W-1:0] o_rdata
);

    logic [pfba_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic [pfba_pkg::WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Hold read data until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: src/pfba_word_eval.sv
// Combinational evaluation of one bitmap word: lowest clear bit and the
// set/clear variants of the word. Depends on pfba_pkg.
`default_nettype none

module pfba_word_eval (
    input  wire logic [pfba_pkg::WORD_W-1:0] i_word,
    input  wire logic [pfba_pkg::BIT_W-1:0]  i_bit,
    output pfba_pkg::t_word_eval             o_eval
);

    logic [pfba_pkg::WORD_W-1:0] w_clear;
    logic [pfba_pkg::BIT_W-1:0]  w_low;
    logic [pfba_pkg::WORD_W-1:0] w_low_mask;
    logic [pfba_pkg::WORD_W-1:0] w_bit_mask;

    assign w_clear = ~i_word;

    // Priority encode: scan from the top so the lowest clear bit wins.
    always_comb begin
        w_low = '0;
        for (int b = pfba_pkg::WORD_W - 1; b >= 0; b--) begin
            if (w_clear[b]) begin
                w_low = pfba_pkg::BIT_W'(b);
            end
        end
    end

    assign w_low_mask = pfba_pkg::WORD_W'(1) << w_low;
    assign w_bit_mask = pfba_pkg::WORD_W'(1) << i_bit;

    always_comb begin
        o_eval.has_clear    = |w_clear;
        o_eval.low_bit      = w_low;
        o_eval.bit_used     = i_word[i_bit];
        o_eval.word_low_set = i_word | w_low_mask;
        o_eval.word_bit_set = i_word | w_bit_mask;
        o_eval.word_bit_clr = i_word & ~w_bit_mask;
    end

endmodule

`default_nettype wire

// File: src/page_frame_bitmap_allocator.sv
// Page frame allocator over a used/free bitmap of page frames.
//
// Input channel (i_valid / o_stall): one command word carries i_cmd and
// i_frame_in. Allocate ignores the frame; free and reserve act on it.
// Output channel (o_valid / i_stall): one result word per command with the
// allocated frame, a status code and the free frame count after the command.
//
// Timing: the bitmap read issues on the accepting edge and the result
// register loads from the evaluate step once the output register is free,
// after a further bitmap read for each full word an allocate scans past (one
// 32-frame word per cycle, set by the single read port). One command is in
// flight at a time; the next is accepted the cycle after the result is registered.
//
// Reset: the bitmap memory is swept to all-free, one word a cycle, across
// all NUM_WORDS words (512 by default). o_stall is held high during the
// sweep. The free count resets to NUM_FRAMES and the search hint to zero.
//
// Receiver stall: a finished result waits in the output register, and a new
// command is still accepted meanwhile. If a second result is ready before
// the first is taken, the sequencer holds in its evaluate step.
`default_nettype none

module page_frame_bitmap_allocator #(
    parameter int NUM_WORDS  = pfba_pkg::NUM_WORDS_DEF,
    parameter int NUM_FRAMES = pfba_pkg::NUM_FRAMES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [pfba_pkg::CMD_W-1:0]    i_cmd,
    input  wire logic [pfba_pkg::FRAME_W-1:0]  i_frame_in,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic      [pfba_pkg::FRAME_W-1:0]  o_frame_out,
    output logic      [pfba_pkg::STATUS_W-1:0] o_status,
    output logic      [pfba_pkg::COUNT_W-1:0]  o_free_count
);

    localparam int AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int HW = $clog2(NUM_FRAMES + 1);   // hint, 0..NUM_FRAMES
    localparam int CW = $clog2(NUM_FRAMES + 1);   // free count
    localparam int GW = AW + pfba_pkg::BIT_W;     // frame found by a scan
    localparam logic [AW-1:0] LAST_WORD = AW'(NUM_WORDS - 1);

    // Sequencer state
    pfba_pkg::t_state  r_state, n_state;
    logic [pfba_pkg::CMD_W-1:0]   r_cmd, n_cmd;
    logic [pfba_pkg::FRAME_W-1:0] r_frame, n_frame;
    logic [AW-1:0]     r_word, n_word;
    logic              r_bad, n_bad;
    logic [HW-1:0]     r_hint, n_hint;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_clr, n_clr;

    // Result register
    logic                          r_ovalid;
    logic [pfba_pkg::FRAME_W-1:0]  r_frame_out;
    pfba_pkg::t_status             r_status;
    logic [pfba_pkg::COUNT_W-1:0]  r_free_out;

    // Memory port
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [pfba_pkg::WORD_W-1:0] mem_wdata;
    logic                        mem_re;
    logic [AW-1:0]               mem_raddr;
    logic [pfba_pkg::WORD_W-1:0] mem_rdata;

    // Evaluate step
    pfba_pkg::t_word_eval        w_eval;
    logic [GW-1:0]               w_got;
    logic                        w_out_free;
    logic                        w_done;
    logic                        w_finish;
    logic                        w_wr;
    logic [pfba_pkg::WORD_W-1:0] w_wdata;
    logic [CW-1:0]               w_cnt;
    logic [HW-1:0]               w_hint;
    logic [pfba_pkg::FRAME_W-1:0] w_res_frame;
    pfba_pkg::t_status           w_res_status;

    pfba_bitmap_ram #(
        .DEPTH (NUM_WORDS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    pfba_word_eval u_eval (
        .i_word (mem_rdata),
        .i_bit  (r_frame[pfba_pkg::BIT_W-1:0]),
        .o_eval (w_eval)
    );

    assign w_got      = {r_word, w_eval.low_bit};
    assign w_out_free = !r_ovalid || !i_stall;

    // Accept only in idle; the sweep and the evaluate step both hold off input.
    assign o_stall = (r_state != pfba_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfba_pkg::S_CLEAR;
            r_hint  <= '0;
            r_count <= CW'(NUM_FRAMES);
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_hint  <= n_hint;
            r_count <= n_count;
            r_clr   <= n_clr;
        end
    end

    // Per-command context; no reset needed.
    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_frame <= n_frame;
        r_word  <= n_word;
        r_bad   <= n_bad;
    end

    // Work out what the current word means for the command in flight.
    always_comb begin
        w_done       = 1'b0;
        w_wr         = 1'b0;
        w_wdata      = mem_rdata;
        w_cnt        = r_count;
        w_hint       = r_hint;
        w_res_frame  = '0;
        w_res_status = pfba_pkg::STAT_OK;
        case (r_cmd)
            pfba_pkg::CMD_ALLOC: begin
                if (r_bad) begin
                    w_done       = 1'b1;
                    w_res_status = pfba_pkg::STAT_EXHAUSTED;
                end else if (w_eval.has_clear) begin
                    w_done = 1'b1;
                    if (32'(w_got) >= NUM_FRAMES) begin
                        // lowest clear bit lies past the last frame
                        w_res_status = pfba_pkg::STAT_EXHAUSTED;
                    end else begin
                        w_wr        = 1'b1;
                        w_wdata     = w_eval.word_low_set;
                        w_cnt       = r_count - 1'b1;
                        w_hint      = HW'(w_got) + 1'b1;
                        w_res_frame = pfba_pkg::FRAME_W'(w_got);
                    end
                end else if (r_word == LAST_WORD) begin
                    w_done       = 1'b1;
                    w_res_status = pfba_pkg::STAT_EXHAUSTED;
                end
            end
            pfba_pkg::CMD_FREE: begin
                w_done = 1'b1;
                if (r_bad || !w_eval.bit_used) begin
                    w_res_status = pfba_pkg::STAT_DOUBLE_FREE;
                end else begin
                    w_wr    = 1'b1;
                    w_wdata = w_eval.word_bit_clr;
                    w_cnt   = r_count + 1'b1;
                    if (HW'(r_frame) < r_hint) begin
                        w_hint = HW'(r_frame);
                    end
                end
            end
            pfba_pkg::CMD_RESERVE: begin
                w_done = 1'b1;
                if (r_bad || w_eval.bit_used) begin
                    w_res_status = pfba_pkg::STAT_RESERVE_USED;
                end else begin
                    w_wr    = 1'b1;
                    w_wdata = w_eval.word_bit_set;
                    w_cnt   = r_count - 1'b1;
                end
            end
            default: begin
                // unused command code: report ok, touch nothing
                w_done = 1'b1;
            end
        endcase
    end

    // Next state, memory port and context updates.
    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_frame   = r_frame;
        n_word    = r_word;
        n_bad     = r_bad;
        n_hint    = r_hint;
        n_count   = r_count;
        n_clr     = r_clr;
        mem_we    = 1'b0;
        mem_waddr = r_word;
        mem_wdata = w_wdata;
        mem_re    = 1'b0;
        mem_raddr = r_word;
        w_finish  = 1'b0;
        case (r_state)
            pfba_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == LAST_WORD) begin
                    n_clr   = '0;
                    n_state = pfba_pkg::S_IDLE;
                end
            end
            pfba_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_cmd   = i_cmd;
                    n_frame = i_frame_in;
                    if (i_cmd == pfba_pkg::CMD_ALLOC) begin
                        n_word = AW'(r_hint >> pfba_pkg::BIT_W);
                        n_bad  = (32'(r_hint >> pfba_pkg::BIT_W) >= NUM_WORDS);
                    end else begin
                        n_word = AW'(i_frame_in >> pfba_pkg::BIT_W);
                        n_bad  = !((32'(i_frame_in) < NUM_FRAMES) &&
                                   (32'(i_frame_in >> pfba_pkg::BIT_W) < NUM_WORDS));
                    end
                    mem_re    = 1'b1;
                    mem_raddr = n_word;
                    n_state   = pfba_pkg::S_EVAL;
                end
            end
            pfba_pkg::S_EVAL: begin
                if (!w_done) begin
                    // full word: advance the scan to the next word
                    n_word    = r_word + 1'b1;
                    mem_re    = 1'b1;
                    mem_raddr = n_word;
                end else if (w_out_free) begin
                    w_finish = 1'b1;
                    mem_we   = w_wr;
                    n_count  = w_cnt;
                    n_hint   = w_hint;
                    n_state  = pfba_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pfba_pkg::S_CLEAR;
            end
        endcase
    end

    // Result register: load on finish, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_finish) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_frame_out <= w_res_frame;
            r_status    <= w_res_status;
            r_free_out  <= pfba_pkg::COUNT_W'(w_cnt);
        end
    end

    assign o_valid      = r_ovalid;
    assign o_frame_out  = r_frame_out;
    assign o_status     = r_status;
    assign o_free_count = r_free_out;

    // A result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |-> (!r_ovalid || !i_stall))
        else $error("result overwrote a pending result");

    // Bitmap writes happen only in the sweep or when a command finishes.
    a_write_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> ((r_state == pfba_pkg::S_CLEAR) || w_finish))
        else $error("unexpected bitmap write");

    // A successful allocate takes exactly one frame off the count.
    a_alloc_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_finish && (r_cmd == pfba_pkg::CMD_ALLOC) &&
         (w_res_status == pfba_pkg::STAT_OK))
        |=> (r_count == $past(r_count) - 1'b1))
        else $error("free count not decremented on allocate");

    // A failing command leaves count and hint alone.
    a_fail_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_finish && (w_res_status != pfba_pkg::STAT_OK))
        |=> ($stable(r_count) && $stable(r_hint)))
        else $error("state changed on a failing command");

endmodule

`default_nettype wire

// File: bench/pfba_checker.sv
// Checker for the page frame bitmap allocator: mirrors the bitmap, free count and hint,
// predicts one result word per accepted command and compares results field by field.
// Depends on pfba_pkg for widths, command codes and status codes.
module pfba_checker
    import pfba_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cmd_valid,
    input  wire logic               i_cmd_stall,
    input  wire logic [CMD_W-1:0]   i_cmd,
    input  wire logic [FRAME_W-1:0] i_frame_in,
    input  wire logic               i_res_valid,
    input  wire logic               i_res_stall,
    input  wire logic [FRAME_W-1:0] i_frame_out,
    input  wire logic [STATUS_W-1:0] i_status,
    input  wire logic [COUNT_W-1:0] i_free_count,
    output int                      o_fail_count,
    output int                      o_outstanding,
    output int                      o_checked,
    output int                      o_exhausted,
    output int                      o_refused
);

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        t_status            status;
        logic [COUNT_W-1:0] free_count;
    } t_alloc_outcome;

    logic [WORD_W-1:0]  frame_map [NUM_WORDS_DEF];
    logic [COUNT_W-1:0] frames_free;
    logic [COUNT_W-1:0] alloc_hint;
    t_alloc_outcome     outcome_q [$];
    int                 fails = 0;
    int                 checked = 0;
    int                 exhausted = 0;
    int                 refused = 0;

    // Apply one command to the mirrored state and return the result it owes.
    function automatic t_alloc_outcome apply_command(input logic [CMD_W-1:0] cmd,
                                                     input logic [FRAME_W-1:0] f);
        t_alloc_outcome res;
        int   w;
        int   b;
        int   pick;
        logic found;
        res.frame  = '0;
        res.status = STAT_OK;
        found      = 1'b0;
        pick       = 0;
        case (cmd)
            CMD_ALLOC: begin
                // Scan whole words upward from the hint's word; lowest clear bit wins.
                for (w = int'(alloc_hint >> 5); w < NUM_WORDS_DEF && !found; w++) begin
                    if (frame_map[w] != '1) begin
                        for (b = 0; b < WORD_W && !found; b++) begin
                            if (!frame_map[w][b]) begin
                                found = 1'b1;
                                pick  = w * WORD_W + b;
                            end
                        end
                    end
                end
                if (found && pick < NUM_FRAMES_DEF) begin
                    frame_map[pick / WORD_W][pick % WORD_W] = 1'b1;
                    frames_free = frames_free - 1'b1;
                    alloc_hint  = COUNT_W'(pick + 1);
                    res.frame   = FRAME_W'(pick);
                end else begin
                    res.status = STAT_EXHAUSTED;
                end
            end
            CMD_FREE: begin
                if (!frame_map[f[FRAME_W-1:BIT_W]][f[BIT_W-1:0]]) begin
                    res.status = STAT_DOUBLE_FREE;
                end else begin
                    frame_map[f[FRAME_W-1:BIT_W]][f[BIT_W-1:0]] = 1'b0;
                    frames_free = frames_free + 1'b1;
                    if ({1'b0, f} < alloc_hint)
                        alloc_hint = {1'b0, f};
                end
            end
            CMD_RESERVE: begin
                if (frame_map[f[FRAME_W-1:BIT_W]][f[BIT_W-1:0]]) begin
                    res.status = STAT_RESERVE_USED;
                end else begin
                    frame_map[f[FRAME_W-1:BIT_W]][f[BIT_W-1:0]] = 1'b1;
                    frames_free = frames_free - 1'b1;
                end
            end
            default: ;
        endcase
        res.free_count = frames_free;
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_alloc_outcome want;
        if (!i_rst_n) begin
            foreach (frame_map[i])
                frame_map[i] = '0;
            frames_free = COUNT_W'(NUM_FRAMES_DEF);
            alloc_hint  = '0;
            outcome_q.delete();
        end else begin
            // Retire the result word first, so a stray one is never matched
            // against a command accepted on the same edge.
            if (i_res_valid && !i_res_stall) begin
                if (outcome_q.size() == 0) begin
                    $error("result word with nothing outstanding: frame %0d status %0d count %0d",
                           i_frame_out, i_status, i_free_count);
                    fails++;
                end else begin
                    want = outcome_q.pop_front();
                    if (i_frame_out !== want.frame) begin
                        $error("frame_out: expected %0d, actual %0d", want.frame, i_frame_out);
                        fails++;
                    end
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, i_status);
                        fails++;
                    end
                    if (i_free_count !== want.free_count) begin
                        $error("free_count: expected %0d, actual %0d",
                               want.free_count, i_free_count);
                        fails++;
                    end
                    checked++;
                    if (want.status == STAT_EXHAUSTED)
                        exhausted++;
                    else if (want.status != STAT_OK)
                        refused++;
                end
            end
            if (i_cmd_valid && !i_cmd_stall)
                outcome_q.push_back(apply_command(i_cmd, i_frame_in));
        end
        o_fail_count  <= fails;
        o_outstanding <= outcome_q.size();
        o_checked     <= checked;
        o_exhausted   <= exhausted;
        o_refused     <= refused;
    end

endmodule

// File: bench/tb_page_frame_bitmap_allocator.sv
// Top of the allocator testbench: clock, reset, command and result drivers, watchdog, verdict.
// Depends on pfba_pkg, page_frame_bitmap_allocator and pfba_checker.
module tb_page_frame_bitmap_allocator;
    import pfba_pkg::*;

    // Longest legal quiet stretch: the reset sweep over 512 words, a full 512-word
    // scan that ends in exhaustion, and the forced receiver hold-off, each well
    // under this limit.
    localparam int STUCK_LIMIT = 4000;
    localparam int HOLD_LEN    = 400;
    localparam int BURST_LEN   = 185;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [CMD_W-1:0]    i_cmd;
    logic [FRAME_W-1:0]  i_frame_in;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [FRAME_W-1:0]  o_frame_out;
    logic [STATUS_W-1:0] o_status;
    logic [COUNT_W-1:0]  o_free_count;

    int fail_count;
    int outstanding;
    int checked;
    int exhausted;
    int refused;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cmds_sent      = 0;
    logic hold_wanted  = 1'b0;
    int hold_cycles    = 0;

    always #1 i_clk = ~i_clk;

    page_frame_bitmap_allocator dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_frame_in   (i_frame_in),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_frame_out  (o_frame_out),
        .o_status     (o_status),
        .o_free_count (o_free_count)
    );

    pfba_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (i_valid),
        .i_cmd_stall   (o_stall),
        .i_cmd         (i_cmd),
        .i_frame_in    (i_frame_in),
        .i_res_valid   (o_valid),
        .i_res_stall   (i_stall),
        .i_frame_out   (o_frame_out),
        .i_status      (o_status),
        .i_free_count  (o_free_count),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_checked     (checked),
        .o_exhausted   (exhausted),
        .o_refused     (refused)
    );

    // Offer one command word. Drive on the falling edge, hold the payload until
    // a rising edge sees the block not stalling. Valid stays high straight into
    // the next word when no idle cycle is drawn.
    task automatic send_word(input t_cmd c, input logic [FRAME_W-1:0] f);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_cmd      <= c;
        i_frame_in <= f;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        cmds_sent++;
    endtask

    // Mixed commands. Most frames fall in a low window, where allocations
    // cluster, so frees and reserves hit used frames often; the rest span
    // the whole frame range.
    task automatic random_burst(input int count, input int window);
        t_cmd              c;
        int                r;
        logic [FRAME_W-1:0] f;
        repeat (count) begin
            r = $urandom_range(0, 99);
            c = (r < 40) ? CMD_ALLOC : (r < 72) ? CMD_FREE : CMD_RESERVE;
            if ($urandom_range(0, 3) == 0)
                f = FRAME_W'($urandom_range(0, NUM_FRAMES_DEF - 1));
            else
                f = FRAME_W'($urandom_range(0, window - 1));
            send_word(c, f);
        end
    endtask

    // Receiver: stall at the current rate, except for one long hold-off on
    // request, counted here so the sender keeps pushing into a full block.
    always @(negedge i_clk) begin
        if (hold_wanted && hold_cycles < HOLD_LEN) begin
            i_stall     <= 1'b1;
            hold_cycles <= hold_cycles + 1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Watchdog: end the run when no word moves on either channel for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STUCK_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet = 0;
            else
                quiet++;
        end
        $error("no word moved for %0d cycles, %0d results outstanding", STUCK_LIMIT, outstanding);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        int send_mix [4];
        int recv_mix [4];
        send_mix = '{0, 58, 0, 31};
        recv_mix = '{0, 0, 58, 31};
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_cmd      = CMD_ALLOC;
        i_frame_in = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, empty map: sequential allocation, hint drop on free,
        // double free, reserve of free and used frames, word boundaries,
        // the top frame and alternating frame bit patterns.
        send_word(CMD_ALLOC, '0);
        send_word(CMD_ALLOC, '1);
        send_word(CMD_ALLOC, '0);
        send_word(CMD_FREE, 14'd1);
        send_word(CMD_FREE, 14'd1);
        send_word(CMD_ALLOC, '0);
        send_word(CMD_RESERVE, 14'd16383);
        send_word(CMD_RESERVE, 14'd16383);
        send_word(CMD_FREE, 14'd16383);
        send_word(CMD_FREE, 14'd16383);
        send_word(CMD_RESERVE, 14'd0);
        send_word(CMD_RESERVE, 14'd31);
        send_word(CMD_RESERVE, 14'd32);
        send_word(CMD_ALLOC, '0);
        send_word(CMD_FREE, 14'd0);
        send_word(CMD_FREE, 14'd2);
        send_word(CMD_ALLOC, '0);
        send_word(CMD_ALLOC, '0);
        send_word(CMD_ALLOC, '0);
        send_word(CMD_RESERVE, 14'h1555);
        send_word(CMD_RESERVE, 14'h2aaa);
        send_word(CMD_FREE, 14'h1555);
        send_word(CMD_FREE, 14'h2aaa);
        send_word(CMD_FREE, 14'd8192);

        // Sparse map, four idling mixes; the first also carries the long
        // receiver hold-off.
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = send_mix[p];
            recv_stall_pct = recv_mix[p];
            if (p == 0)
                hold_wanted = 1'b1;
            random_burst(BURST_LEN, 384);
        end

        // Wider frame window, same four idling mixes.
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = send_mix[p];
            recv_stall_pct = recv_mix[p];
            random_burst(BURST_LEN, 512);
        end

        // Drain: drop valid, stop stalling, wait for every owed result, then
        // watch a tail longer than the longest scan for stray words.
        @(negedge i_clk);
        i_valid <= 1'b0;
        recv_stall_pct = 0;
        while (outstanding != 0)
            @(posedge i_clk);
        repeat (600) @(posedge i_clk);

        $display("run covered %0d commands and %0d checked results over two frame windows",
                 cmds_sent, checked);
        $display("%0d exhausted allocations, %0d refused frees or reserves, %0d-cycle hold-off",
                 exhausted, refused, hold_cycles);
        if (fail_count == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
